FILE: rtl/art_pkg.sv
`default_nettype none
package art_pkg;
    localparam int DEPTH = 64;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] CMD_SEND  = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    localparam logic [2:0] K_ADDED   = 3'd0;
    localparam logic [2:0] K_DROPPED = 3'd1;
    localparam logic [2:0] K_ACKED   = 3'd2;
    localparam logic [2:0] K_MISS    = 3'd3;
    localparam logic [2:0] K_RESEND  = 3'd4;
    localparam logic [2:0] K_GAVEUP  = 3'd5;
    localparam logic [2:0] K_IDLE    = 3'd6;

    localparam logic [1:0] REG_MAX_PENDING = 2'd0;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_MAX_RETRIES = 2'd2;

    localparam logic [6:0]  RST_MAX_PENDING = 7'd50;
    localparam logic [31:0] RST_ACK_TIMEOUT = 32'd3000;
    localparam logic [3:0]  RST_MAX_RETRIES = 4'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] msg_tag;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] tag_out;
        logic [3:0]  retry_number;
        logic [6:0]  pending_count;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] ts;
        logic [3:0]  retries;
    } t_entry;
endpackage
`default_nettype wire

FILE: rtl/ack_retransmit_tracker.sv
// A send that drops nothing answers in the cycle after start.
// Ack, check and dropping send walk the table entry by entry, each entry
// with a memory read, then evaluate/compact.
// One word in flight at a time; results come out as one-cycle strobes, a check
// may give one per entry. Reset: table empty, registers to defaults.
`default_nettype none
module ack_retransmit_tracker
    import art_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire t_item       i_item,
    output logic             busy,
    output logic             o_strobe,
    output t_result          o_result,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_EV   = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_entry mem [DEPTH];
    t_entry r_rdata;

    logic [6:0]    r_max_pending;
    logic [31:0]   r_ack_timeout;
    logic [3:0]    r_max_retries;
    t_item         r_item, n_item;
    logic [CW-1:0] r_cnt, n_cnt, r_end, n_end, r_p, n_p, r_w, n_w;
    logic          r_found, n_found;
    logic [31:0]   r_droptag, n_droptag;
    logic          r_hv, n_hv;
    t_result       r_hold, n_hold;
    logic          r_ov, n_ov;
    t_result       r_out, n_out;

    logic          we;
    logic [AW-1:0] waddr;
    t_entry        wdata;
    logic [CW-1:0] lim;
    logic          drop;
    logic [31:0]   age;
    logic          due;

    always_comb begin
        lim = r_max_pending;
        if (r_max_pending == 7'd0) begin
            lim = CW'(1);
        end else if (r_max_pending > 7'(DEPTH)) begin
            lim = CW'(DEPTH);
        end
        drop = (r_cnt >= lim) && (r_cnt != '0);
        age  = r_item.now_ms - r_rdata.ts;
        due  = age > r_ack_timeout;
    end

    always_comb begin
        n_state = r_state; n_item = r_item; n_cnt = r_cnt; n_end = r_end;
        n_p = r_p; n_w = r_w; n_found = r_found; n_droptag = r_droptag;
        n_hv = r_hv; n_hold = r_hold; n_ov = 1'b0; n_out = r_out;
        we = 1'b0; waddr = r_w[AW-1:0]; wdata = r_rdata;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item = i_item; n_end = r_cnt; n_p = '0; n_w = '0;
                    n_found = 1'b0; n_hv = 1'b0;
                    priority if (i_item.cmd == CMD_SEND && !drop) begin
                        we = 1'b1; waddr = r_cnt[AW-1:0];
                        wdata = '{tag: i_item.msg_tag, ts: i_item.now_ms, retries: 4'd0};
                        n_cnt = r_cnt + 1'b1;
                        n_ov = 1'b1;
                        n_out = '{kind: K_ADDED, tag_out: i_item.msg_tag, retry_number: 4'd0,
                                  pending_count: 7'(n_cnt), last: 1'b1};
                    end else if (i_item.cmd == CMD_SEND) begin
                        n_state = S_RD;
                    end else if (i_item.cmd == CMD_ACK || i_item.cmd == CMD_CHECK) begin
                        n_state = (r_cnt == '0) ? S_FIN : S_RD;
                    end else begin
                        n_ov = 1'b1;
                        n_out = '{kind: K_IDLE, tag_out: 32'd0, retry_number: 4'd0,
                                  pending_count: 7'(r_cnt), last: 1'b1};
                    end
                end
            end
            S_RD: n_state = S_EV;
            S_EV: begin
                logic rm;
                rm = 1'b0;
                unique case (r_item.cmd)
                    CMD_SEND: begin
                        if (r_p == '0) begin
                            rm = 1'b1; n_droptag = r_rdata.tag;
                        end
                    end
                    CMD_ACK: begin
                        if (!r_found && r_rdata.tag == r_item.msg_tag) begin
                            rm = 1'b1; n_found = 1'b1;
                        end
                    end
                    default: begin
                        if (due) begin
                            if (r_hv) begin
                                n_ov = 1'b1; n_out = r_hold;
                            end
                            n_hv = 1'b1;
                            if (r_rdata.retries >= r_max_retries) begin
                                rm = 1'b1;
                                n_hold = '{kind: K_GAVEUP, tag_out: r_rdata.tag,
                                           retry_number: 4'd0,
                                           pending_count: 7'(r_cnt - 1'b1), last: 1'b0};
                            end else begin
                                wdata.retries = r_rdata.retries + 4'd1;
                                wdata.ts = r_item.now_ms;
                                n_hold = '{kind: K_RESEND, tag_out: r_rdata.tag,
                                           retry_number: wdata.retries,
                                           pending_count: 7'(r_cnt), last: 1'b0};
                            end
                        end
                    end
                endcase
                if (rm) begin
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    we = 1'b1; n_w = r_w + 1'b1;
                end
                n_p = r_p + 1'b1;
                n_state = (n_p == r_end) ? S_FIN : S_RD;
            end
            S_FIN: begin
                n_state = S_IDLE;
                n_ov = 1'b1;
                unique case (r_item.cmd)
                    CMD_SEND: begin
                        we = 1'b1;
                        wdata = '{tag: r_item.msg_tag, ts: r_item.now_ms, retries: 4'd0};
                        n_cnt = r_cnt + 1'b1;
                        n_out = '{kind: K_DROPPED, tag_out: r_droptag, retry_number: 4'd0,
                                  pending_count: 7'(n_cnt), last: 1'b1};
                    end
                    CMD_ACK: begin
                        n_out = '{kind: r_found ? K_ACKED : K_MISS, tag_out: r_item.msg_tag,
                                  retry_number: 4'd0, pending_count: 7'(r_cnt), last: 1'b1};
                    end
                    default: begin
                        if (r_hv) begin
                            n_out = r_hold; n_out.last = 1'b1;
                        end else begin
                            n_out = '{kind: K_IDLE, tag_out: 32'd0, retry_number: 4'd0,
                                      pending_count: 7'(r_cnt), last: 1'b1};
                        end
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[r_p[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item; r_end <= n_end; r_p <= n_p; r_w <= n_w;
        r_found <= n_found; r_droptag <= n_droptag; r_hold <= n_hold; r_out <= n_out;
        r_hv <= n_hv;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_ov <= 1'b0;
            r_max_pending <= RST_MAX_PENDING;
            r_ack_timeout <= RST_ACK_TIMEOUT;
            r_max_retries <= RST_MAX_RETRIES;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_ov <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MAX_PENDING: r_max_pending <= i_cfg_wdata[6:0];
                    REG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_wdata;
                    REG_MAX_RETRIES: r_max_retries <= i_cfg_wdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_ov;
    assign o_result = r_out;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("entry count above table depth");
    a_midword_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy) else $error("non-final word after walk");
    a_start_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_strobe || busy) else $error("accepted command got no word");
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |-> !busy) else $error("final word while still busy");
endmodule
`default_nettype wire
